/* design/pid_controller_step_unit_defines.svh */
// Assertion macros for the PID step unit.
`ifndef PID_CONTROLLER_STEP_UNIT_DEFINES_SVH
`define PID_CONTROLLER_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define PCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pcs_pkg.sv */
package pcs_pkg;

    typedef struct packed {
        logic signed [31:0] target;
        logic signed [31:0] measurement;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clipped;
    } out_word_t;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t REG_GAIN_P        = 3'd0;
    localparam cfg_index_t REG_GAIN_I        = 3'd1;
    localparam cfg_index_t REG_GAIN_D        = 3'd2;
    localparam cfg_index_t REG_TIME_STEP     = 3'd3;
    localparam cfg_index_t REG_INV_TIME_STEP = 3'd4;

    localparam logic [23:0] GAIN_P_RESET        = 24'd42598;
    localparam logic [23:0] GAIN_I_RESET        = 24'd524;
    localparam logic [23:0] GAIN_D_RESET        = 24'd49152;
    localparam logic [15:0] TIME_STEP_RESET     = 16'd6554;
    localparam logic [23:0] INV_TIME_STEP_RESET = 24'd40960;

    // sequencer steps; all but drain issue a product, later ones add the last
    typedef logic [3:0] step_t;

    localparam step_t OP_TS_ERR_LO   = 4'd0;
    localparam step_t OP_TS_ERR_HI   = 4'd1;
    localparam step_t OP_IVT_DIFF_LO = 4'd2;
    localparam step_t OP_IVT_DIFF_HI = 4'd3;
    localparam step_t OP_GP_ERR_LO   = 4'd4;
    localparam step_t OP_GP_ERR_HI   = 4'd5;
    localparam step_t OP_GI_SUM_LO   = 4'd6;
    localparam step_t OP_GI_SUM_HI   = 4'd7;
    localparam step_t OP_GD_DER_LO   = 4'd8;
    localparam step_t OP_GD_DER_HI   = 4'd9;
    localparam step_t OP_DRAIN       = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

/* design/pid_controller_step_unit.sv */
// Each input word runs through ten passes of one shared 25x25 signed
// multiplier, a drain step and a saturation step; the next input word is
// taken only in the idle state, after the previous word has been handed to
// the output register.
// An output word may wait under stall while the next input word is taken.
// Reset: gains and sample-period registers take their defaults, the integral
// and the previous error clear to zero, no output word is pending.
`include "pid_controller_step_unit_defines.svh"

module pid_controller_step_unit
    import pcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_word,
    input  logic       cfg_write,
    input  cfg_index_t cfg_index,
    input  logic [23:0] cfg_data
);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic [23:0] gain_p_reg, gain_i_reg, gain_d_reg, inv_time_step_reg;
    logic [15:0] time_step_reg;

    logic signed [47:0] error_sum_reg, error_sum_next;
    logic signed [32:0] last_error_reg;

    logic signed [32:0] err_reg;
    logic signed [33:0] diff_reg;
    logic signed [45:0] deriv_reg;
    logic signed [49:0] prod_reg, prod_next;
    logic               prod_hi_reg;
    logic signed [75:0] acc_reg, acc_next;
    logic               clip_reg;
    logic               out_valid_reg;
    out_word_t          out_word_reg;

    logic               in_take;
    logic               out_take;
    logic               out_free;
    logic signed [32:0] err_in;
    logic signed [33:0] diff_in;
    logic signed [24:0] op_a, op_b;
    logic signed [75:0] prod_ext, prod_shifted, acc_base;
    logic               group_start;
    logic               acc_add;
    logic signed [33:0] inc;
    logic signed [48:0] sum_wide;
    logic               sum_ovf;
    logic               drive_ovf;
    logic signed [31:0] drive_sat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign err_in  = {in_word.target[31], in_word.target}
                   - {in_word.measurement[31], in_word.measurement};
    assign diff_in = {err_in[32], err_in} - {last_error_reg[32], last_error_reg};

    // operand select for the shared multiplier; wide operands go in 24-bit chunks
    always_comb
    begin
        unique case (step_reg)
            OP_TS_ERR_LO:
            begin
                op_a = $signed({9'b0, time_step_reg});
                op_b = $signed({1'b0, err_reg[23:0]});
            end
            OP_TS_ERR_HI:
            begin
                op_a = $signed({9'b0, time_step_reg});
                op_b = $signed({{16{err_reg[32]}}, err_reg[32:24]});
            end
            OP_IVT_DIFF_LO:
            begin
                op_a = $signed({1'b0, inv_time_step_reg});
                op_b = $signed({1'b0, diff_reg[23:0]});
            end
            OP_IVT_DIFF_HI:
            begin
                op_a = $signed({1'b0, inv_time_step_reg});
                op_b = $signed({{15{diff_reg[33]}}, diff_reg[33:24]});
            end
            OP_GP_ERR_LO:
            begin
                op_a = $signed({gain_p_reg[23], gain_p_reg});
                op_b = $signed({1'b0, err_reg[23:0]});
            end
            OP_GP_ERR_HI:
            begin
                op_a = $signed({gain_p_reg[23], gain_p_reg});
                op_b = $signed({{16{err_reg[32]}}, err_reg[32:24]});
            end
            OP_GI_SUM_LO:
            begin
                op_a = $signed({gain_i_reg[23], gain_i_reg});
                op_b = $signed({1'b0, error_sum_reg[23:0]});
            end
            OP_GI_SUM_HI:
            begin
                op_a = $signed({gain_i_reg[23], gain_i_reg});
                op_b = $signed({error_sum_reg[47], error_sum_reg[47:24]});
            end
            OP_GD_DER_LO:
            begin
                op_a = $signed({gain_d_reg[23], gain_d_reg});
                op_b = $signed({1'b0, deriv_reg[23:0]});
            end
            OP_GD_DER_HI:
            begin
                op_a = $signed({gain_d_reg[23], gain_d_reg});
                op_b = $signed({{3{deriv_reg[45]}}, deriv_reg[45:24]});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    // accumulate the product registered in the step before
    assign prod_ext     = {{26{prod_reg[49]}}, prod_reg};
    assign prod_shifted = prod_hi_reg ? {prod_ext[51:0], 24'b0} : prod_ext;
    assign group_start  = (step_reg == OP_TS_ERR_HI) || (step_reg == OP_IVT_DIFF_HI)
                       || (step_reg == OP_GP_ERR_HI);
    assign acc_base     = group_start ? '0 : acc_reg;
    assign acc_next     = acc_base + prod_shifted;
    assign acc_add      = (state_reg == ST_RUN) && (step_reg != OP_TS_ERR_LO);

    // integral update from the finished err*dt group
    assign inc      = acc_reg[49:16];
    assign sum_wide = {error_sum_reg[47], error_sum_reg} + {{15{inc[33]}}, inc};
    assign sum_ovf  = (sum_wide[48] != sum_wide[47]);

    always_comb
    begin
        if (sum_ovf)
        begin
            error_sum_next = sum_wide[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            error_sum_next = sum_wide[47:0];
        end
    end

    // output saturation
    assign drive_ovf = !((&acc_reg[75:47]) || !(|acc_reg[75:47]));
    assign drive_sat = drive_ovf ? (acc_reg[75] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}})
                                 : acc_reg[47:16];

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = OP_TS_ERR_LO;
                end
            end
            ST_RUN:
            begin
                if (step_reg == OP_DRAIN)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            step_reg          <= OP_TS_ERR_LO;
            out_valid_reg     <= 1'b0;
            error_sum_reg     <= '0;
            last_error_reg    <= '0;
            gain_p_reg        <= GAIN_P_RESET;
            gain_i_reg        <= GAIN_I_RESET;
            gain_d_reg        <= GAIN_D_RESET;
            time_step_reg     <= TIME_STEP_RESET;
            inv_time_step_reg <= INV_TIME_STEP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_take)
            begin
                last_error_reg <= err_in;
            end

            if ((state_reg == ST_RUN) && (step_reg == OP_IVT_DIFF_HI))
            begin
                error_sum_reg <= error_sum_next;
            end

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_GAIN_P:        gain_p_reg        <= cfg_data;
                    REG_GAIN_I:        gain_i_reg        <= cfg_data;
                    REG_GAIN_D:        gain_d_reg        <= cfg_data;
                    REG_TIME_STEP:     time_step_reg     <= cfg_data[15:0];
                    REG_INV_TIME_STEP: inv_time_step_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            err_reg  <= err_in;
            diff_reg <= diff_in;
        end

        if (state_reg == ST_RUN)
        begin
            prod_reg    <= prod_next;
            prod_hi_reg <= step_reg[0];
        end

        if (acc_add)
        begin
            acc_reg <= acc_next;
        end

        if ((state_reg == ST_RUN) && (step_reg == OP_IVT_DIFF_HI))
        begin
            clip_reg <= sum_ovf;
        end

        if ((state_reg == ST_RUN) && (step_reg == OP_GP_ERR_HI))
        begin
            deriv_reg <= acc_reg[57:12];
        end

        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_word_reg.drive   <= drive_sat;
            out_word_reg.clipped <= clip_reg || drive_ovf;
        end
    end

    `PCS_ASSERT_NOW(a_out_from_finish, $rose(out_valid_reg), $past(state_reg == ST_FINISH), "output word raised outside finish")
    `PCS_ASSERT_NOW(a_step_bound, state_reg == ST_RUN, step_reg <= OP_DRAIN, "sequencer step out of range")
    `PCS_ASSERT_NEXT(a_finish_loads, (state_reg == ST_FINISH) && out_free, (state_reg == ST_IDLE) && out_valid_reg, "finish did not hand over the word")
    `PCS_ASSERT_NEXT(a_sum_hold, state_reg != ST_RUN, $stable(error_sum_reg), "integral changed outside the sequence")

endmodule

/* tb/tb_pid_controller_step_unit.sv */
`timescale 1ns / 1ps

module tb_pid_controller_step_unit;
    import pcs_pkg::*;

    localparam cfg_index_t REG_SPARE_LO = 3'd5;
    localparam cfg_index_t REG_SPARE_HI = 3'd7;

    localparam logic signed [127:0] INTEG_MAX = (128'sd1 <<< 47) - 128'sd1;
    localparam logic signed [127:0] INTEG_MIN = -(128'sd1 <<< 47);
    localparam logic signed [127:0] DRIVE_MAX = (128'sd1 <<< 31) - 128'sd1;
    localparam logic signed [127:0] DRIVE_MIN = -(128'sd1 <<< 31);

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_LSB = 32'hFFFF_FFFF;

    localparam int SETTLE = 16;
    localparam int RAMP_UP = 60;
    localparam int RAMP_DOWN = 90;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_word;
    logic        cfg_write = 1'b0;
    cfg_index_t  cfg_index = REG_GAIN_P;
    logic [23:0] cfg_data = '0;

    in_word_t  sample_q[$];
    out_word_t drive_q[$];
    out_word_t want_word;
    bit        quiet = 1'b0;
    int        send_gap = 0;
    int        stall_left = 0;
    int        mismatches = 0;

    // controller shadow: registers and loop state
    logic [23:0]        kp = GAIN_P_RESET;
    logic [23:0]        ki = GAIN_I_RESET;
    logic [23:0]        kd = GAIN_D_RESET;
    logic [15:0]        dt = TIME_STEP_RESET;
    logic [23:0]        inv_dt = INV_TIME_STEP_RESET;
    logic signed [47:0] integ = '0;
    logic signed [32:0] prev_err = '0;

    pid_controller_step_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_word_t control_step(in_word_t w);
        logic signed [127:0] err;
        logic signed [127:0] inc;
        logic signed [127:0] deriv;
        logic signed [127:0] level;
        logic signed [127:0] acc;
        out_word_t r;
        r.clipped = 1'b0;
        err = $signed(w.target) - $signed(w.measurement);
        inc = (err * $signed({1'b0, dt})) >>> 16;
        deriv = ((err - prev_err) * $signed({1'b0, inv_dt})) >>> 12;
        level = integ + inc;
        if (level > INTEG_MAX)
        begin
            level = INTEG_MAX;
            r.clipped = 1'b1;
        end
        else if (level < INTEG_MIN)
        begin
            level = INTEG_MIN;
            r.clipped = 1'b1;
        end
        integ = level[47:0];
        prev_err = err[32:0];
        acc = $signed(kp) * err + $signed(ki) * level + $signed(kd) * deriv;
        level = acc >>> 16;
        if (level > DRIVE_MAX)
        begin
            r.drive = DRIVE_MAX[31:0];
            r.clipped = 1'b1;
        end
        else if (level < DRIVE_MIN)
        begin
            r.drive = DRIVE_MIN[31:0];
            r.clipped = 1'b1;
        end
        else
        begin
            r.drive = level[31:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GAIN_P:        kp = cfg_data;
                    REG_GAIN_I:        ki = cfg_data;
                    REG_GAIN_D:        kd = cfg_data;
                    REG_TIME_STEP:     dt = cfg_data[15:0];
                    REG_INV_TIME_STEP: inv_dt = cfg_data;
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
                drive_q.push_back(control_step(in_word));
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                begin
                    $error("unexpected output word: drive %0d clipped %0b",
                           out_word.drive, out_word.clipped);
                    mismatches++;
                end
                else
                begin
                    want_word = drive_q.pop_front();
                    if (out_word.drive !== want_word.drive)
                    begin
                        $error("drive: expected %0d, actual %0d",
                               want_word.drive, out_word.drive);
                        mismatches++;
                    end
                    if (out_word.clipped !== want_word.clipped)
                    begin
                        $error("clipped: expected %0b, actual %0b",
                               want_word.clipped, out_word.clipped);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (send_gap > 0 || sample_q.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                in_word <= sample_q.pop_front();
                if (!quiet && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 14);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 13);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [23:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic add_sample(logic [31:0] t, logic [31:0] m);
        in_word_t w;
        w.target = t;
        w.measurement = m;
        sample_q.push_back(w);
    endtask

    task automatic wait_idle();
        while (sample_q.size() != 0 || in_valid || drive_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(0, 1 << 18) - (1 << 17));
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'd1;
            2:       return 16'd0;
            3:       return 16'($urandom_range(1, 65535));
            default: return 16'($urandom_range(1, 8192));
        endcase
    endfunction

    function automatic logic [23:0] pick_inv_dt();
        case ($urandom_range(0, 7))
            0:       return 24'hFFFFFF;
            1:       return 24'd1;
            2:       return 24'd0;
            3:       return 24'($urandom);
            default: return 24'($urandom_range(1, 1 << 17));
        endcase
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(0, 4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return Q_NEG_LSB;
            default: return Q_ONE;
        endcase
    endfunction

    task automatic random_phase(int count, bit no_idle);
        logic [31:0] base;
        write_reg(REG_GAIN_P, pick_gain());
        write_reg(REG_GAIN_I, pick_gain());
        write_reg(REG_GAIN_D, pick_gain());
        write_reg(REG_TIME_STEP, pick_dt());
        write_reg(REG_INV_TIME_STEP, pick_inv_dt());
        if ($urandom_range(0, 2) == 0)
            write_reg(cfg_index_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 24'($urandom));
        @(negedge clk);
        quiet = no_idle;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0: add_sample($urandom, $urandom);
                1: add_sample(pick_edge(), pick_edge());
                default:
                begin
                    base = $urandom;
                    add_sample(base, base + $urandom_range(0, 1 << 21) - (1 << 20));
                end
            endcase
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings; first step sees the whole error as derivative
        @(negedge clk);
        add_sample(Q_ONE, '0);
        add_sample('0, '0);
        add_sample(Q_MAX, Q_MIN);
        add_sample(Q_MIN, Q_MAX);
        add_sample(Q_MAX, Q_MAX);
        add_sample(Q_MIN, Q_MIN);
        add_sample(Q_NEG_LSB, '0);
        add_sample('0, Q_NEG_LSB);
        add_sample(Q_MIN, '0);
        wait_idle();

        write_reg(REG_GAIN_P, 24'h7FFFFF);
        write_reg(REG_GAIN_I, 24'h800000);
        write_reg(REG_GAIN_D, 24'h800000);
        write_reg(REG_TIME_STEP, 16'hFFFF);
        write_reg(REG_INV_TIME_STEP, 24'hFFFFFF);
        write_reg(REG_SPARE_LO, 24'($urandom));
        write_reg(REG_SPARE_HI, 24'($urandom));
        @(negedge clk);
        add_sample(Q_MAX, Q_MIN);
        add_sample('0, '0);
        add_sample(Q_MIN, Q_MAX);
        wait_idle();

        // zero dt freezes the integral, zero 1/dt kills the derivative
        write_reg(REG_GAIN_P, 24'h010000);
        write_reg(REG_GAIN_I, 24'h010000);
        write_reg(REG_GAIN_D, 24'h010000);
        write_reg(REG_TIME_STEP, 16'd0);
        write_reg(REG_INV_TIME_STEP, 24'd0);
        @(negedge clk);
        add_sample(Q_ONE, '0);
        add_sample(32'h0003_0000, Q_ONE);
        add_sample(Q_MIN, '0);
        wait_idle();

        write_reg(REG_GAIN_P, 24'h800000);
        write_reg(REG_GAIN_I, 24'h7FFFFF);
        write_reg(REG_GAIN_D, 24'h7FFFFF);
        write_reg(REG_TIME_STEP, 16'd1);
        write_reg(REG_INV_TIME_STEP, 24'd1);
        @(negedge clk);
        add_sample(Q_MAX, Q_MIN);
        add_sample('0, '0);
        add_sample(Q_NEG_LSB, Q_ONE);
        wait_idle();

        for (int p = 0; p < 8; p++)
            random_phase(200, p == 7);

        // integral ramps up and back down; drive follows the integral shifted right by 16
        write_reg(REG_GAIN_P, 24'd0);
        write_reg(REG_GAIN_I, 24'd1);
        write_reg(REG_GAIN_D, 24'd0);
        write_reg(REG_TIME_STEP, 16'hFFFF);
        write_reg(REG_INV_TIME_STEP, pick_inv_dt());
        @(negedge clk);
        quiet = 1'b1;
        for (int i = 0; i < RAMP_UP; i++)
            add_sample(Q_MAX, Q_MIN);
        for (int i = 0; i < RAMP_DOWN; i++)
            add_sample(Q_MIN, Q_MAX);
        wait_idle();

        if (mismatches == 0 && drive_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/pcs_pkg.sv
design/pid_controller_step_unit.sv
tb/tb_pid_controller_step_unit.sv
